### src/qstc_pkg.sv
package qstc_pkg;

    localparam int COMPONENT_BITS_DEF = 15;
    localparam int COMP_W             = 16;
    localparam int LANES              = 3;
    localparam int LANE_STAGES        = 5;
    localparam int SQRT_STAGES        = 8;

    // 1/sqrt2 in Q0.30, rounded
    localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
        logic signed [COMP_W-1:0] comp_w;
        logic [15:0]              word_a;
        logic [15:0]              word_b;
        logic [14:0]              word_c;
    } in_item_t;

    typedef struct packed {
        logic [15:0]              packed_a;
        logic [15:0]              packed_b;
        logic [14:0]              packed_c;
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
    } out_item_t;

endpackage

### src/qstc_lane.sv
module qstc_lane #(
    parameter int COMPONENT_BITS = qstc_pkg::COMPONENT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic [qstc_pkg::LANE_STAGES-1:0]     en,
    input  logic signed [16:0]                   v,
    input  logic [COMPONENT_BITS-1:0]            qw,
    output logic [COMPONENT_BITS-1:0]            q,
    output logic signed [qstc_pkg::COMP_W-1:0]   k,
    output logic [29:0]                          sq
);
    import qstc_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam logic [CB-1:0] STEPS = {CB{1'b1}};
    localparam int VS_W   = 18 + CB;
    localparam int T_W    = 47 + CB;
    localparam int P_W    = 31 + CB;
    localparam int Y_W    = 15 + CB;
    localparam int DIV_SH = 2 * CB + 16;
    localparam int R_W    = CB + 17;
    localparam int PR_W   = Y_W + R_W;

    localparam logic signed [VS_W-1:0] STEPS_VS = VS_W'(STEPS);
    localparam logic signed [T_W-1:0]  K_T      = T_W'(INV_SQRT2_Q30);
    localparam logic signed [T_W-1:0]  BIAS     = T_W'(1) << (CB + 44);
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SH) + 64'(STEPS) - 64'd1) / 64'(STEPS);
    localparam logic [R_W-1:0] RECIP = R_W'(RECIP_L);

    // encode path
    logic signed [VS_W-1:0] vs_reg, vs_next;
    logic signed [T_W-1:0]  m_reg, m_next;
    logic signed [T_W-1:0]  t_sum;
    logic [CB+1:0]          t_top;
    logic [CB-1:0]          q3_reg, q3_next, q4_reg, q5_reg;

    // decode path
    logic [CB:0]            twice_q;
    logic [CB-1:0]          mag1_reg, mag1_next;
    logic                   neg1_reg, neg2_reg, neg3_reg;
    logic [P_W-1:0]         p_sum;
    logic [Y_W-1:0]         y_reg, y_next;
    logic [PR_W-1:0]        prod_reg, prod_next;
    logic [14:0]            r_mag;
    logic signed [15:0]     k4_reg, k4_next, k5_reg;
    logic signed [31:0]     sq_full;
    logic [29:0]            sq5_reg;

    always_comb
    begin
        vs_next   = VS_W'(v) * STEPS_VS;
        twice_q   = {qw, 1'b0};
        mag1_next = qw[CB-1] ? CB'(twice_q - {1'b0, STEPS})
                             : CB'({1'b0, STEPS} - twice_q);

        m_next = T_W'(vs_reg) * K_T;
        p_sum  = P_W'(mag1_reg) * P_W'(INV_SQRT2_Q30) + (P_W'(STEPS) << 14);
        y_next = p_sum[15 +: Y_W];

        t_sum = m_reg + BIAS;
        t_top = t_sum[T_W-1 -: CB+2];
        if (t_sum[T_W-1])
            q3_next = '0;
        else if (t_top > (CB+2)'(STEPS))
            q3_next = STEPS;
        else
            q3_next = CB'(t_top);
        // divide by STEPS through the reciprocal, exact over the whole range
        prod_next = PR_W'(y_reg) * PR_W'(RECIP);

        r_mag   = prod_reg[DIV_SH +: 15];
        k4_next = neg3_reg ? 16'(16'd0 - 16'(r_mag)) : 16'(r_mag);

        sq_full = 32'(k4_reg) * 32'(k4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            vs_reg   <= vs_next;
            mag1_reg <= mag1_next;
            neg1_reg <= !qw[CB-1];
        end
        if (en[1])
        begin
            m_reg    <= m_next;
            y_reg    <= y_next;
            neg2_reg <= neg1_reg;
        end
        if (en[2])
        begin
            q3_reg   <= q3_next;
            prod_reg <= prod_next;
            neg3_reg <= neg2_reg;
        end
        if (en[3])
        begin
            q4_reg <= q3_reg;
            k4_reg <= k4_next;
        end
        if (en[4])
        begin
            q5_reg  <= q4_reg;
            k5_reg  <= k4_reg;
            sq5_reg <= sq_full[29:0];
        end
    end

    assign q  = q5_reg;
    assign k  = k5_reg;
    assign sq = sq5_reg;

endmodule

### src/qstc_sqrt.sv
module qstc_sqrt (
    input  logic                                 clk,
    input  logic [qstc_pkg::SQRT_STAGES-1:0]     en,
    input  logic [30:0]                          rad,
    output logic [15:0]                          root,
    output logic [16:0]                          rem
);
    import qstc_pkg::*;

    typedef struct packed {
        logic [30:0] x;
        logic [31:0] res;
    } sq_state_t;

    function automatic sq_state_t sq_step(sq_state_t s, logic [31:0] b);
        sq_state_t   o;
        logic [31:0] trial;
        trial = s.res + b;
        if ({1'b0, s.x} >= trial)
        begin
            o.x   = s.x - 31'(trial);
            o.res = (s.res >> 1) + b;
        end
        else
        begin
            o.x   = s.x;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    sq_state_t stage_in[SQRT_STAGES];
    sq_state_t stage_next[SQRT_STAGES];
    sq_state_t stage_reg[SQRT_STAGES];

    // two result bits per stage, starting from the top pair of the radicand
    always_comb
    begin
        stage_in[0] = '{x: rad, res: 32'd0};
        for (int s = 1; s < SQRT_STAGES; s++)
            stage_in[s] = stage_reg[s-1];
        for (int s = 0; s < SQRT_STAGES; s++)
            stage_next[s] = sq_step(sq_step(stage_in[s], 32'd1 << (30 - 4 * s)),
                                    32'd1 << (28 - 4 * s));
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
            if (en[s])
                stage_reg[s] <= stage_next[s];
    end

    assign root = 16'(stage_reg[SQRT_STAGES-1].res);
    assign rem  = 17'(stage_reg[SQRT_STAGES-1].x);

endmodule

### src/quaternion_smallest_three_codec.sv
// Smallest-three quaternion codec: each transfer carries one encode or decode command and
// yields one result. The block is a 17-stage pipeline that takes one item every cycle while
// no stall holds it; three lanes quantise or dequantise the kept components side by side
// in five stages, and an eight-stage square root rebuilds the dropped component. Each stage
// holds its item when the next stage is full and stalled, so bubbles close up and input is
// taken whenever the pipeline has room, including while a finished result waits.
module quaternion_smallest_three_codec #(
    parameter int COMPONENT_BITS = qstc_pkg::COMPONENT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  qstc_pkg::in_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output qstc_pkg::out_item_t  result
);
    import qstc_pkg::*;

    localparam int CB      = COMPONENT_BITS;
    localparam int ST_IN   = 0;
    localparam int ST_SEL  = 1;
    localparam int ST_LANE = 2;
    localparam int ST_SUM  = ST_LANE + LANE_STAGES;
    localparam int ST_SQRT = ST_SUM + 1;
    localparam int ST_OUT  = ST_SQRT + SQRT_STAGES;
    localparam int NS      = ST_OUT + 1;
    localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

    typedef struct packed {
        logic                             cmd;
        logic [1:0]                       big;
        logic [LANES-1:0][CB-1:0]         q;
        logic [LANES-1:0][COMP_W-1:0]     k;
    } side_t;

    typedef struct packed {
        logic       cmd;
        logic [1:0] big;
    } tag_t;

    // flow control
    logic [NS-1:0] valid_reg, valid_next;
    logic [NS:0]   ready;

    always_comb
    begin
        ready[NS] = !result_stall;
        for (int i = NS - 1; i >= 0; i--)
            ready[i] = !valid_reg[i] || ready[i+1];
        for (int i = 0; i < NS; i++)
            valid_next[i] = ready[i] ? ((i == 0) ? item_valid : valid_reg[(i == 0) ? 0 : i-1])
                                     : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign item_stall   = !ready[ST_IN];
    assign result_valid = valid_reg[ST_OUT];

    // input register
    in_item_t in_reg;

    always_ff @(posedge clk)
    begin
        if (ready[ST_IN])
            in_reg <= item;
    end

    // pick the dropped component and line up the kept three
    logic signed [16:0] comp_ext[4];
    logic [16:0]        mag[4];
    logic [1:0]         big_enc;
    logic [1:0]         idx;
    logic               flip;
    logic signed [16:0] kept_next[LANES];
    logic [CB-1:0]      qw_next[LANES];
    tag_t               sel_tag_next;

    tag_t               sel_tag_reg;
    logic signed [16:0] sel_v_reg[LANES];
    logic [CB-1:0]      sel_qw_reg[LANES];

    always_comb
    begin
        comp_ext[0] = 17'(in_reg.comp_x);
        comp_ext[1] = 17'(in_reg.comp_y);
        comp_ext[2] = 17'(in_reg.comp_z);
        comp_ext[3] = 17'(in_reg.comp_w);
        for (int i = 0; i < 4; i++)
            mag[i] = comp_ext[i][16] ? 17'(17'd0 - comp_ext[i]) : comp_ext[i];
        big_enc = 2'd0;
        for (int i = 1; i < 4; i++)
            if (mag[i] > mag[big_enc])
                big_enc = 2'(i);
        flip = comp_ext[big_enc][16];
        for (int j = 0; j < LANES; j++)
        begin
            idx          = (2'(j) < big_enc) ? 2'(j) : 2'(j + 1);
            kept_next[j] = flip ? 17'(17'd0 - comp_ext[idx]) : comp_ext[idx];
        end
        qw_next[0] = in_reg.word_a[CB-1:0];
        qw_next[1] = in_reg.word_b[CB-1:0];
        qw_next[2] = in_reg.word_c[CB-1:0];
        sel_tag_next.cmd = in_reg.command;
        sel_tag_next.big = (in_reg.command == CMD_DECODE)
                         ? {in_reg.word_b[CB], in_reg.word_a[CB]} : big_enc;
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_SEL])
        begin
            sel_tag_reg <= sel_tag_next;
            for (int j = 0; j < LANES; j++)
            begin
                sel_v_reg[j]  <= kept_next[j];
                sel_qw_reg[j] <= qw_next[j];
            end
        end
    end

    // lanes
    logic [CB-1:0]            lane_q[LANES];
    logic signed [COMP_W-1:0] lane_k[LANES];
    logic [29:0]              lane_sq[LANES];
    tag_t                     lane_tag_reg[LANE_STAGES];

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        qstc_lane #(
            .COMPONENT_BITS (COMPONENT_BITS)
        ) u_lane (
            .clk (clk),
            .en  (ready[ST_LANE +: LANE_STAGES]),
            .v   (sel_v_reg[l]),
            .qw  (sel_qw_reg[l]),
            .q   (lane_q[l]),
            .k   (lane_k[l]),
            .sq  (lane_sq[l])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < LANE_STAGES; s++)
            if (ready[ST_LANE + s])
                lane_tag_reg[s] <= (s == 0) ? sel_tag_reg : lane_tag_reg[(s == 0) ? 0 : s-1];
    end

    // sum of squares and the remainder left for the dropped component
    logic [30:0] sum_sq;
    logic [30:0] rem_reg, rem_next;
    side_t       side_sum_next, side_sum_reg;
    side_t       side_sq_reg[SQRT_STAGES];

    always_comb
    begin
        sum_sq   = 31'(lane_sq[0]) + 31'(lane_sq[1]) + 31'(lane_sq[2]);
        rem_next = (sum_sq >= ONE_Q30) ? 31'd0 : 31'(ONE_Q30 - sum_sq);
        side_sum_next.cmd = lane_tag_reg[LANE_STAGES-1].cmd;
        side_sum_next.big = lane_tag_reg[LANE_STAGES-1].big;
        for (int j = 0; j < LANES; j++)
        begin
            side_sum_next.q[j] = lane_q[j];
            side_sum_next.k[j] = lane_k[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_SUM])
        begin
            rem_reg      <= rem_next;
            side_sum_reg <= side_sum_next;
        end
        for (int s = 0; s < SQRT_STAGES; s++)
            if (ready[ST_SQRT + s])
                side_sq_reg[s] <= (s == 0) ? side_sum_reg : side_sq_reg[(s == 0) ? 0 : s-1];
    end

    logic [15:0] sq_root;
    logic [16:0] sq_rem;

    qstc_sqrt u_sqrt (
        .clk  (clk),
        .en   (ready[ST_SQRT +: SQRT_STAGES]),
        .rad  (rem_reg),
        .root (sq_root),
        .rem  (sq_rem)
    );

    // merge: round the root, slot it in, pack the result
    side_t                    side_out;
    logic [16:0]              root_rnd;
    logic [15:0]              dropped;
    logic [3:0][COMP_W-1:0]   dec_comp;
    out_item_t                out_next, out_reg;

    always_comb
    begin
        side_out = side_sq_reg[SQRT_STAGES-1];
        root_rnd = (sq_rem > 17'(sq_root)) ? 17'(sq_root) + 17'd1 : 17'(sq_root);
        dropped  = (root_rnd > 17'd32767) ? 16'h7FFF : 16'(root_rnd);
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) == side_out.big)
                dec_comp[i] = dropped;
            else if (2'(i) < side_out.big)
                dec_comp[i] = side_out.k[(i < LANES) ? i : 0];
            else
                dec_comp[i] = side_out.k[(i == 0) ? 0 : i-1];
        end
        out_next = '0;
        if (side_out.cmd == CMD_DECODE)
        begin
            out_next.out_x = dec_comp[0];
            out_next.out_y = dec_comp[1];
            out_next.out_z = dec_comp[2];
            out_next.out_w = dec_comp[3];
        end
        else
        begin
            out_next.packed_a = 16'(side_out.q[0]) | (16'(side_out.big[0]) << CB);
            out_next.packed_b = 16'(side_out.q[1]) | (16'(side_out.big[1]) << CB);
            out_next.packed_c = 15'(side_out.q[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_OUT])
            out_reg <= out_next;
    end

    assign result = out_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.packed_a == 16'd0) && (result.packed_b == 16'd0) &&
                          (result.packed_c == 15'd0)) ||
                         ((result.out_x == 16'sd0) && (result.out_y == 16'sd0) &&
                          (result.out_z == 16'sd0) && (result.out_w == 16'sd0)))
        else $error("result carries both encode and decode fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[ST_OUT] |-> !item_stall)
        else $error("input stalled while the pipeline has room");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> valid_reg[ST_IN])
        else $error("accepted transfer lost at the input register");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_SUM] |-> rem_reg <= ONE_Q30)
        else $error("square root radicand above one");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_OUT-1] |-> sq_rem <= {sq_root, 1'b0})
        else $error("square root remainder out of range");
`endif

endmodule

### dv/quaternion_smallest_three_codec_test.sv
module quaternion_smallest_three_codec_test;
    import qstc_pkg::*;

    localparam int CB = COMPONENT_BITS_DEF;
    localparam longint STEPS = (64'd1 << CB) - 1;
    localparam longint ROOT_HALF = 759250125;
    localparam int LATENCY = 17;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    in_item_t item;
    logic result_valid;
    logic result_stall;
    out_item_t result;

    out_item_t codec_expected[$];
    int errors = 0;
    int transfers_in = 0;
    int transfers_out = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    quaternion_smallest_three_codec i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [CB-1:0] quantise(longint v);
        longint t;
        t = v * STEPS * ROOT_HALF + (STEPS + 1) * (64'sd1 <<< 44);
        if (t < 0)
            return '0;
        t = t >>> 45;
        if (t > STEPS)
            t = STEPS;
        return t[CB-1:0];
    endfunction

    function automatic longint dequantise(longint q);
        longint n;
        longint m;
        n = 2 * q - STEPS;
        m = ((n < 0 ? -n : n) * ROOT_HALF + (STEPS << 14)) / (STEPS << 15);
        return n < 0 ? -m : m;
    endfunction

    function automatic longint root_nearest(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r = r + 1;
        if (v > r * r + r)
            r = r + 1;
        return r;
    endfunction

    function automatic out_item_t predict_codec(in_item_t it);
        out_item_t o;
        longint c[4];
        longint k[3];
        longint mag[4];
        longint rem;
        longint d;
        logic [CB-1:0] q[3];
        int big;
        int slot;
        int idx;
        o = '0;
        if (it.command == CMD_ENCODE)
        begin
            c[0] = it.comp_x;
            c[1] = it.comp_y;
            c[2] = it.comp_z;
            c[3] = it.comp_w;
            big = 0;
            slot = 0;
            for (int i = 0; i < 4; i++)
                mag[i] = c[i] < 0 ? -c[i] : c[i];
            for (int i = 1; i < 4; i++)
                if (mag[i] > mag[big])
                    big = i;
            for (int i = 0; i < 4; i++)
            begin
                if (i != big)
                begin
                    q[slot] = quantise(c[big] < 0 ? -c[i] : c[i]);
                    slot++;
                end
            end
            o.packed_a = 16'(q[0]) | (16'(big & 1) << CB);
            o.packed_b = 16'(q[1]) | (16'((big >> 1) & 1) << CB);
            o.packed_c = 15'(q[2]);
        end
        else
        begin
            idx = int'(it.word_a[CB]) | (int'(it.word_b[CB]) << 1);
            k[0] = dequantise(longint'(it.word_a) & STEPS);
            k[1] = dequantise(longint'(it.word_b) & STEPS);
            k[2] = dequantise(longint'(it.word_c) & STEPS);
            rem = (64'sd1 <<< 30) - (k[0] * k[0] + k[1] * k[1] + k[2] * k[2]);
            d = rem > 0 ? root_nearest(rem) : 0;
            if (d > 32767)
                d = 32767;
            slot = 0;
            for (int i = 0; i < 4; i++)
            begin
                if (i == idx)
                    c[i] = d;
                else
                begin
                    c[i] = k[slot];
                    slot++;
                end
            end
            o.out_x = c[0][15:0];
            o.out_y = c[1][15:0];
            o.out_z = c[2][15:0];
            o.out_w = c[3][15:0];
        end
        return o;
    endfunction

    // drive the stall line and check each completed transfer
    always @(posedge clk)
    begin
        out_item_t want;
        cycles <= cycles + 1;
        if (rst_n && result_valid && !result_stall)
        begin
            transfers_out <= transfers_out + 1;
            if (codec_expected.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                want = codec_expected.pop_front();
                if (result.packed_a !== want.packed_a || result.packed_b !== want.packed_b ||
                    result.packed_c !== want.packed_c || result.out_x !== want.out_x ||
                    result.out_y !== want.out_y || result.out_z !== want.out_z ||
                    result.out_w !== want.out_w)
                begin
                    $display("%0t mismatch expected %h actual %h", $time, want, result);
                    errors++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // valid stays high from one transfer into the next; idle cycles drop it
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        codec_expected.push_back(predict_codec(it));
        transfers_in++;
    endtask

    function automatic in_item_t random_noise();
        in_item_t it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        return it;
    endfunction

    // encode item with random signs, one random axis drawn from the upper half of the range
    function automatic in_item_t random_unit();
        in_item_t it;
        logic signed [15:0] v[4];
        int big;
        it = random_noise();
        it.command = CMD_ENCODE;
        big = $urandom_range(3);
        for (int i = 0; i < 4; i++)
            v[i] = 16'(16'($urandom_range(23170)) * ($urandom_range(1) ? -1 : 1));
        v[big] = 16'(16'($urandom_range(32767, 16384)) * ($urandom_range(1) ? -1 : 1));
        it.comp_x = v[0];
        it.comp_y = v[1];
        it.comp_z = v[2];
        it.comp_w = v[3];
        return it;
    endfunction

    task automatic test_encode_edges();
        in_item_t it;
        logic signed [15:0] vals[6] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh5A82,
                                       -16'sh5A82, 16'sh0001};
        it = '0;
        it.command = CMD_ENCODE;
        send_item(it);
        for (int i = 0; i < 6; i++)
        begin
            it.comp_x = vals[i];
            it.comp_y = vals[(i + 1) % 6];
            it.comp_z = vals[(i + 2) % 6];
            it.comp_w = vals[(i + 3) % 6];
            send_item(it);
        end
        // tie in magnitude: lowest index wins
        it.comp_x = 16'sh4000;
        it.comp_y = -16'sh4000;
        it.comp_z = 16'sh4000;
        it.comp_w = -16'sh4000;
        send_item(it);
        it.comp_x = 16'sh8000;
        it.comp_y = 16'sh7FFF;
        it.comp_z = 16'sh8000;
        it.comp_w = 16'sh8000;
        send_item(it);
    endtask

    task automatic test_decode_edges();
        in_item_t it;
        it = '1;
        it.command = CMD_DECODE;
        send_item(it);
        for (int idx = 0; idx < 4; idx++)
        begin
            it = '0;
            it.command = CMD_DECODE;
            it.word_a = {idx[0], 15'h4000};
            it.word_b = {idx[1], 15'h3FFF};
            it.word_c = 15'h4000;
            send_item(it);
        end
        it.word_a = 16'h0000;
        it.word_b = 16'h7FFF;
        it.word_c = 15'h0000;
        send_item(it);
        it.word_a = 16'h7FFF;
        it.word_b = 16'hFFFF;
        it.word_c = 15'h7FFF;
        send_item(it);
    endtask

    task automatic test_random(int count, int idle, int stall);
        in_item_t it;
        send_idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0, 1: it = random_noise();
                2, 3, 4, 5:
                begin
                    it = random_unit();
                end
                default:
                begin
                    it = random_noise();
                    it.command = CMD_DECODE;
                end
            endcase
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encode_edges();
        test_decode_edges();
        test_random(500, 0, 0);
        test_random(500, 74, 0);
        test_random(500, 0, 74);
        test_random(500, 29, 29);
        item_valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        while (codec_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        $display("covered %0d transfers in, %0d out: encode and decode edges, ties, random",
                 transfers_in, transfers_out);
        $display("idle and stall phases exercised on both channels");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
    end
endmodule
